>>> rtl/core/vfcm_pkg.sv
// Shared types and constants for the voxel face mesher.
// Depends on nothing; every module of the block but vfcm_ram imports it.
`timescale 1ns / 1ps
`default_nettype none
package vfcm_pkg;

    localparam int DEF_SIZE_X = 16;
    localparam int DEF_SIZE_Y = 16;
    localparam int DEF_SIZE_Z = 16;

    localparam int POS_W   = 4;
    localparam int COLOR_W = 32;
    localparam int VB_W    = 16;
    localparam int CRD_W   = 10;   // signed working width of a neighbor coordinate
    localparam int VOX_W   = COLOR_W + 1;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    // request kinds
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_MESH  = 2'd2;

    localparam logic [2:0] DIR_LAST = 3'd5;

    typedef struct packed {
        logic [1:0]         action;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic               voxel_solid;
        logic [COLOR_W-1:0] voxel_color;
    } cmd_t;

    typedef struct packed {
        logic               face_valid;
        logic [2:0]         face_dir;
        logic [1:0]         ao_corner0;
        logic [1:0]         ao_corner1;
        logic [1:0]         ao_corner2;
        logic [1:0]         ao_corner3;
        logic [COLOR_W-1:0] face_color;
        logic [VB_W-1:0]    vertex_base;
        logic               dirty_flag;
        logic               index_overflow;
        logic               last;
    } res_t;

    // front to back: head of the request queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } fe2be_t;

    // back to front: queue pop and clearing status
    typedef struct packed {
        logic pop;
        logic clear_busy;
    } be2fe_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_CMP,
        ST_MS_CEN,
        ST_FC_ISSUE,
        ST_FC_CHK,
        ST_AO_ISSUE,
        ST_AO_CAP,
        ST_FACE,
        ST_DONE
    } st_t;

endpackage
`default_nettype wire

>>> rtl/core/voxel_face_cull_ao_mesher_unit.sv
// Top level of the voxel face mesher with ambient occlusion.
// Instantiates vfcm_front and vfcm_back; depends on vfcm_pkg.
// After reset the voxel store is cleared, one entry a cycle, all SIZE_X*SIZE_Y*SIZE_Z entries
// (4096 by default); s_axis_tready stays low during the clearing pass.
// Start, unknown and out-of-grid requests go straight to the result; a write reads the
// cell and rewrites it if it differs; a mesh request reads the center cell, per face the
// neighbor for culling (not on the grid edge) and per emitted face the 3x3 plane, and an
// output stall holds it. All cost is in the single read port of the voxel store.
// Asynchronous active-low reset clears counters, flags and the outside_solid register.
`timescale 1ns / 1ps
`default_nettype none
module voxel_face_cull_ao_mesher_unit #(
    parameter int SIZE_X = vfcm_pkg::DEF_SIZE_X,
    parameter int SIZE_Y = vfcm_pkg::DEF_SIZE_Y,
    parameter int SIZE_Z = vfcm_pkg::DEF_SIZE_Z
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // pos_x[3:0], pos_y[7:4], pos_z[11:8], voxel_solid[12], voxel_color[44:13]
    input  wire logic [vfcm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // face_dir[2:0], ao_corner0..3[10:3], face_color[42:11], vertex_base[58:43],
    // dirty_flag[59], index_overflow[60]
    output logic [vfcm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // face_valid[0]
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_data
);
    import vfcm_pkg::*;

    fe2be_t fe;
    be2fe_t be;
    res_t   res;
    logic   outside_reg;

    // outside_solid register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outside_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            outside_reg <= cfg_data;
        end
    end

    vfcm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .fe            (fe),
        .be            (be)
    );

    vfcm_back #(
        .SIZE_X (SIZE_X),
        .SIZE_Y (SIZE_Y),
        .SIZE_Z (SIZE_Z)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fe            (fe),
        .be            (be),
        .outside_solid (outside_reg),
        .res           (res),
        .res_valid     (m_axis_tvalid),
        .res_ready     (m_axis_tready)
    );

    // pack the result
    assign m_axis_tdata = {3'b000, res.index_overflow, res.dirty_flag, res.vertex_base,
                           res.face_color, res.ao_corner3, res.ao_corner2,
                           res.ao_corner1, res.ao_corner0, res.face_dir};
    assign m_axis_tuser = res.face_valid;
    assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

>>> rtl/core/vfcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vfcm_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/vfcm_front.sv
// Front end: takes stream requests, unpacks them and holds them in a two-entry queue.
// Depends on vfcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vfcm_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [vfcm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [1:0]                  s_axis_tuser,
    output vfcm_pkg::fe2be_t                 fe,
    input  wire vfcm_pkg::be2fe_t            be
);
    import vfcm_pkg::*;

    cmd_t       q_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       in_cmd;

    // unpack the request
    always_comb
    begin
        in_cmd.action      = s_axis_tuser;
        in_cmd.pos_x       = s_axis_tdata[3:0];
        in_cmd.pos_y       = s_axis_tdata[7:4];
        in_cmd.pos_z       = s_axis_tdata[11:8];
        in_cmd.voxel_solid = s_axis_tdata[12];
        in_cmd.voxel_color = s_axis_tdata[44:13];
    end

    assign s_axis_tready = (cnt_reg != 2'd2) && !be.clear_busy;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign fe.valid      = (cnt_reg != 2'd0);
    assign fe.cmd        = q_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = be.pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, be.pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/vfcm_back.sv
// Back end: sequencer over the voxel store, culling, occlusion and the result register.
// Depends on vfcm_pkg and vfcm_ram.
`timescale 1ns / 1ps
`default_nettype none
module vfcm_back #(
    parameter int SIZE_X = vfcm_pkg::DEF_SIZE_X,
    parameter int SIZE_Y = vfcm_pkg::DEF_SIZE_Y,
    parameter int SIZE_Z = vfcm_pkg::DEF_SIZE_Z
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire vfcm_pkg::fe2be_t  fe,
    output vfcm_pkg::be2fe_t       be,
    input  wire logic              outside_solid,
    output vfcm_pkg::res_t         res,
    output logic                   res_valid,
    input  wire logic              res_ready
);
    import vfcm_pkg::*;

    localparam int VOL = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int AW  = $clog2(VOL);
    localparam logic signed [CRD_W-1:0] SX = CRD_W'(SIZE_X);
    localparam logic signed [CRD_W-1:0] SY = CRD_W'(SIZE_Y);
    localparam logic signed [CRD_W-1:0] SZ = CRD_W'(SIZE_Z);

    st_t              state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [2:0]       dir_reg, dir_next;
    logic [1:0]       ia_reg, ia_next, ib_reg, ib_next;
    logic             cell_ok_reg, cell_ok_next;
    logic             nb_reg [0:2][0:2];
    logic             nb_we;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [VB_W-1:0]  vcnt_reg, vcnt_next;
    logic             dirty_reg, dirty_next;
    logic             ovf_reg, ovf_next;
    res_t             pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [AW-1:0]    clr_reg, clr_next;
    res_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [VOX_W-1:0] ram_wdata, ram_rdata;

    cmd_t             cur;
    logic signed [CRD_W-1:0] cen [0:2];
    logic signed [CRD_W-1:0] pc  [0:2];
    logic signed [CRD_W-1:0] cel [0:2];
    logic signed [CRD_W-1:0] da, db, step;
    logic [1:0]       axis, a_ax, b_ax;
    logic             cen_ok, cel_ok;
    logic [AW-1:0]    cen_addr, cel_addr;
    logic             slot_free;
    logic [1:0]       ao [0:3];
    logic [VB_W:0]    vsum;
    res_t             status;

    function automatic logic in_grid(input logic signed [CRD_W-1:0] x,
                                     input logic signed [CRD_W-1:0] y,
                                     input logic signed [CRD_W-1:0] z);
        return (x >= 0) && (x < SX) && (y >= 0) && (y < SY) && (z >= 0) && (z < SZ);
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic signed [CRD_W-1:0] x,
                                                input logic signed [CRD_W-1:0] y,
                                                input logic signed [CRD_W-1:0] z);
        return AW'((int'(z) * SIZE_Y + int'(y)) * SIZE_X + int'(x));
    endfunction

    vfcm_ram #(
        .WIDTH (VOX_W),
        .DEPTH (VOL)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // coordinates of the center, the face neighbor and the plane cell
    always_comb
    begin
        cur    = (state_reg == ST_IDLE) ? fe.cmd : cmd_reg;
        cen[0] = CRD_W'(cur.pos_x);
        cen[1] = CRD_W'(cur.pos_y);
        cen[2] = CRD_W'(cur.pos_z);
        axis   = dir_reg[2:1];
        a_ax   = (axis == 2'd0) ? 2'd1 : 2'd0;
        b_ax   = (axis == 2'd2) ? 2'd1 : 2'd2;
        step   = dir_reg[0] ? -CRD_W'(1) : CRD_W'(1);
        da     = CRD_W'(ia_reg) - CRD_W'(1);
        db     = CRD_W'(ib_reg) - CRD_W'(1);
        for (int i = 0; i < 3; i++)
        begin
            pc[i]  = cen[i] + ((axis == 2'(i)) ? step : CRD_W'(0));
            cel[i] = pc[i];
            if (state_reg == ST_AO_ISSUE)
            begin
                cel[i] = pc[i] + ((a_ax == 2'(i)) ? da : CRD_W'(0))
                               + ((b_ax == 2'(i)) ? db : CRD_W'(0));
            end
        end
        cen_ok   = in_grid(cen[0], cen[1], cen[2]);
        cel_ok   = in_grid(cel[0], cel[1], cel[2]);
        cen_addr = cell_addr(cen[0], cen[1], cen[2]);
        cel_addr = cell_addr(cel[0], cel[1], cel[2]);
    end

    // occlusion of the four corners from the 3x3 plane
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic s1, s2, sc;
            logic [1:0] ka, kb;
            ka = (k >= 2) ? 2'd2 : 2'd0;
            kb = (k % 2 == 1) ? 2'd2 : 2'd0;
            s1 = nb_reg[1][kb];
            s2 = nb_reg[ka][1];
            sc = nb_reg[ka][kb];
            ao[k] = (s1 && s2) ? 2'd0 : 2'd3 - {1'b0, s1} - {1'b0, s2} - {1'b0, sc};
        end
    end

    assign slot_free = !out_valid_reg || res_ready;
    assign vsum      = {1'b0, vcnt_reg} + (VB_W+1)'(4);

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        dir_next        = dir_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        cell_ok_next    = cell_ok_reg;
        nb_we           = 1'b0;
        color_next      = color_reg;
        vcnt_next       = vcnt_reg;
        dirty_next      = dirty_reg;
        ovf_next        = ovf_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = cen_addr;
        ram_wdata       = {cmd_reg.voxel_solid, cmd_reg.voxel_color};
        ram_raddr       = (state_reg == ST_IDLE) ? cen_addr : cel_addr;
        be.pop          = 1'b0;
        be.clear_busy   = (state_reg == ST_CLEAR);

        status                = '0;
        status.dirty_flag     = dirty_reg;
        status.index_overflow = ovf_reg;
        status.last           = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(VOL - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (fe.valid)
                begin
                    be.pop     = 1'b1;
                    cmd_next   = fe.cmd;
                    dir_next   = 3'd0;
                    state_next = ST_DONE;
                    case (fe.cmd.action)
                        ACT_WRITE:
                        begin
                            if (cen_ok)
                            begin
                                state_next = ST_WR_CMP;
                            end
                        end
                        ACT_START:
                        begin
                            vcnt_next  = '0;
                            dirty_next = 1'b0;
                        end
                        ACT_MESH:
                        begin
                            if (cen_ok)
                            begin
                                state_next = ST_MS_CEN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WR_CMP:
            begin
                if (ram_rdata != {cmd_reg.voxel_solid, cmd_reg.voxel_color})
                begin
                    ram_we     = 1'b1;
                    dirty_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_MS_CEN:
            begin
                color_next = ram_rdata[COLOR_W-1:0];
                state_next = ram_rdata[COLOR_W] ? ST_FC_ISSUE : ST_DONE;
            end
            ST_FC_ISSUE:
            begin
                ia_next = 2'd0;
                ib_next = 2'd0;
                if (cel_ok)
                begin
                    state_next = ST_FC_CHK;
                end
                else
                begin
                    state_next = ST_AO_ISSUE;
                end
            end
            ST_FC_CHK:
            begin
                if (!ram_rdata[COLOR_W])
                begin
                    state_next = ST_AO_ISSUE;
                end
                else if (dir_reg == DIR_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    dir_next   = dir_reg + 3'd1;
                    state_next = ST_FC_ISSUE;
                end
            end
            ST_AO_ISSUE:
            begin
                cell_ok_next = cel_ok;
                state_next   = ST_AO_CAP;
            end
            ST_AO_CAP:
            begin
                nb_we = 1'b1;
                if (ib_reg == 2'd2)
                begin
                    ib_next = 2'd0;
                    ia_next = ia_reg + 2'd1;
                end
                else
                begin
                    ib_next = ib_reg + 2'd1;
                end
                state_next = (ia_reg == 2'd2 && ib_reg == 2'd2) ? ST_FACE : ST_AO_ISSUE;
            end
            ST_FACE:
            begin
                // the held face goes out once the next one is known
                if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_valid_next          = 1'b1;
                    pend_next.face_valid     = 1'b1;
                    pend_next.face_dir       = dir_reg;
                    pend_next.ao_corner0     = ao[0];
                    pend_next.ao_corner1     = ao[1];
                    pend_next.ao_corner2     = ao[2];
                    pend_next.ao_corner3     = ao[3];
                    pend_next.face_color     = color_reg;
                    pend_next.vertex_base    = vcnt_reg;
                    pend_next.dirty_flag     = dirty_reg;
                    pend_next.index_overflow = ovf_reg || vsum[VB_W];
                    pend_next.last           = 1'b0;
                    vcnt_next                = vsum[VB_W-1:0];
                    ovf_next                 = ovf_reg || vsum[VB_W];
                    if (dir_reg == DIR_LAST)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        dir_next   = dir_reg + 3'd1;
                        state_next = ST_FC_ISSUE;
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next = status;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg       <= '0;
            dirty_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            dir_reg        <= '0;
            ia_reg         <= '0;
            ib_reg         <= '0;
        end
        else
        begin
            vcnt_reg       <= vcnt_next;
            dirty_reg      <= dirty_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
            dir_reg        <= dir_next;
            ia_reg         <= ia_next;
            ib_reg         <= ib_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cell_ok_reg <= cell_ok_next;
        color_reg   <= color_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        if (nb_we)
        begin
            nb_reg[ia_reg][ib_reg] <= cell_ok_reg ? ram_rdata[COLOR_W] : outside_solid;
        end
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    // no request leaves the queue during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !be.pop)
        else $error("request popped during clearing pass");

    // a store write after clearing always marks the grid dirty
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_CLEAR) |=> dirty_reg)
        else $error("voxel changed without dirty");

    // overflow is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    // a held face only exists while a mesh request is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held face left behind");

endmodule
`default_nettype wire

>>> sim/voxel_face_cull_ao_mesher_unit_tb.sv
// Testbench for the voxel face mesher: drives write, start and mesh requests,
// predicts every face and status result, and checks the output stream.
// Depends on vfcm_pkg and voxel_face_cull_ao_mesher_unit.
`timescale 1ns / 1ps
`default_nettype none
module voxel_face_cull_ao_mesher_unit_tb;
    import vfcm_pkg::*;

    localparam int GRID = 16;
    localparam longint CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic m_axis_tlast;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    voxel_face_cull_ao_mesher_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Shadow copy of block state
    logic        shadow_solid [GRID*GRID*GRID];
    logic [31:0] shadow_color [GRID*GRID*GRID];
    logic [15:0] shadow_vcount;
    logic        shadow_dirty;
    logic        shadow_ovf;
    logic        shadow_outside;

    res_t face_queue[$];
    int   mismatches = 0;
    int   send_idle_pct;
    int   recv_stall_pct;
    longint cycles = 0;

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic solid_cell(int x, int y, int z);
        if (x < 0 || x >= GRID || y < 0 || y >= GRID || z < 0 || z >= GRID)
            return shadow_outside;
        return shadow_solid[(z*GRID + y)*GRID + x];
    endfunction

    function automatic logic [1:0] occlusion(logic s1, logic s2, logic c);
        if (s1 && s2)
            return 2'd0;
        return 2'(3 - s1 - s2 - c);
    endfunction

    function automatic res_t status_result();
        res_t r;
        r = '0;
        r.dirty_flag = shadow_dirty;
        r.index_overflow = shadow_ovf;
        r.last = 1'b1;
        return r;
    endfunction

    // Predict results of one request and advance the shadow state
    task automatic predict_faces(cmd_t c);
        int idx, dir, axis, k, a, b, da, db, n;
        int p[3], q1[3], q2[3], qc[3];
        logic [16:0] sum;
        res_t r;
        idx = (int'(c.pos_z)*GRID + int'(c.pos_y))*GRID + int'(c.pos_x);
        n = 0;
        if (c.action == ACT_WRITE)
        begin
            if (shadow_solid[idx] != c.voxel_solid || shadow_color[idx] != c.voxel_color)
            begin
                shadow_dirty = 1'b1;
                shadow_solid[idx] = c.voxel_solid;
                shadow_color[idx] = c.voxel_color;
            end
        end
        else if (c.action == ACT_START)
        begin
            shadow_vcount = '0;
            shadow_dirty = 1'b0;
        end
        else if (c.action == ACT_MESH && shadow_solid[idx])
        begin
            for (dir = 0; dir < 6; dir++)
            begin
                axis = dir >> 1;
                p[0] = int'(c.pos_x); p[1] = int'(c.pos_y); p[2] = int'(c.pos_z);
                p[axis] += (dir & 1) ? -1 : 1;
                if (p[axis] >= 0 && p[axis] < GRID && solid_cell(p[0], p[1], p[2]))
                    continue;
                a = (axis == 0) ? 1 : 0;
                b = (axis == 2) ? 1 : 2;
                r = '0;
                r.face_valid = 1'b1;
                r.face_dir = 3'(dir);
                for (k = 0; k < 4; k++)
                begin
                    da = (k & 2) ? 1 : -1;
                    db = (k & 1) ? 1 : -1;
                    q1 = p; q2 = p; qc = p;
                    q1[b] += db;
                    q2[a] += da;
                    qc[a] += da;
                    qc[b] += db;
                    case (k)
                        0: r.ao_corner0 = occlusion(solid_cell(q1[0], q1[1], q1[2]),
                            solid_cell(q2[0], q2[1], q2[2]), solid_cell(qc[0], qc[1], qc[2]));
                        1: r.ao_corner1 = occlusion(solid_cell(q1[0], q1[1], q1[2]),
                            solid_cell(q2[0], q2[1], q2[2]), solid_cell(qc[0], qc[1], qc[2]));
                        2: r.ao_corner2 = occlusion(solid_cell(q1[0], q1[1], q1[2]),
                            solid_cell(q2[0], q2[1], q2[2]), solid_cell(qc[0], qc[1], qc[2]));
                        default: r.ao_corner3 = occlusion(solid_cell(q1[0], q1[1], q1[2]),
                            solid_cell(q2[0], q2[1], q2[2]), solid_cell(qc[0], qc[1], qc[2]));
                    endcase
                end
                r.face_color = shadow_color[idx];
                r.vertex_base = shadow_vcount;
                sum = {1'b0, shadow_vcount} + 17'd4;
                if (sum[16])
                    shadow_ovf = 1'b1;
                shadow_vcount = sum[15:0];
                r.dirty_flag = shadow_dirty;
                r.index_overflow = shadow_ovf;
                r.last = 1'b0;
                face_queue.push_back(r);
                n++;
            end
            if (n > 0)
                face_queue[$].last = 1'b1;
        end
        if (n == 0)
            face_queue.push_back(status_result());
    endtask

    // Send one request; predict at acceptance
    task automatic send_request(logic [1:0] act, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                                logic solid, logic [31:0] color);
        cmd_t c;
        c.action = act; c.pos_x = x; c.pos_y = y; c.pos_z = z;
        c.voxel_solid = solid; c.voxel_color = color;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {3'b0, color, solid, z, y, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_faces(c);
    endtask

    // Output checker with random backpressure
    always @(posedge clk)
    begin
        res_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = '0;
            got.face_valid = m_axis_tuser[0];
            got.face_dir = m_axis_tdata[2:0];
            got.ao_corner0 = m_axis_tdata[4:3];
            got.ao_corner1 = m_axis_tdata[6:5];
            got.ao_corner2 = m_axis_tdata[8:7];
            got.ao_corner3 = m_axis_tdata[10:9];
            got.face_color = m_axis_tdata[42:11];
            got.vertex_base = m_axis_tdata[58:43];
            got.dirty_flag = m_axis_tdata[59];
            got.index_overflow = m_axis_tdata[60];
            got.last = m_axis_tlast;
            if (face_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = face_queue.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (face_queue.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_outside(logic v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_outside = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int snd, int rcv);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
    endtask

    // Corners, edges, special cases
    task automatic test_directed();
        send_request(ACT_MESH, 0, 0, 0, 0, 0);                 // air: status only
        send_request(ACT_WRITE, 0, 0, 0, 1, 32'hFFFF_FFFF);
        send_request(ACT_WRITE, 0, 0, 0, 1, 32'hFFFF_FFFF);    // unchanged write
        send_request(ACT_MESH, 0, 0, 0, 0, 0);                 // corner cube, six faces
        send_request(ACT_WRITE, 1, 0, 0, 1, 32'h0000_0001);
        send_request(ACT_WRITE, 0, 1, 0, 1, 32'h8000_0000);
        send_request(ACT_WRITE, 1, 1, 0, 1, 32'h1234_5678);
        send_request(ACT_MESH, 0, 0, 0, 0, 0);
        send_request(ACT_MESH, 1, 1, 0, 0, 0);
        send_request(ACT_START, 15, 15, 15, 1, 32'hFFFF_FFFF);
        send_request(ACT_WRITE, 15, 15, 15, 1, 32'hA5A5_5A5A);
        send_request(ACT_MESH, 15, 15, 15, 1, 32'hFFFF_FFFF);
        send_request(2'd3, 15, 15, 15, 1, 32'hFFFF_FFFF);      // unknown action
        send_request(ACT_WRITE, 1, 1, 0, 0, 32'h1234_5678);    // color only kept
        send_request(ACT_MESH, 1, 1, 0, 0, 0);                 // air again
        send_request(ACT_START, 0, 0, 0, 0, 0);
    endtask

    // Fill a block so mesh requests see occlusion
    task automatic test_random(int count, int span);
        int i, sel;
        logic [3:0] bx, by, bz;
        for (i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            bx = (span == 16) ? 4'($urandom_range(15)) : 4'($urandom_range(span - 1)) + 4'd6;
            by = (span == 16) ? 4'($urandom_range(15)) : 4'($urandom_range(span - 1)) + 4'd6;
            bz = (span == 16) ? 4'($urandom_range(15)) : 4'($urandom_range(span - 1)) + 4'd6;
            if ($urandom_range(9) == 0)
            begin
                bx = $urandom_range(1) ? 4'd15 : 4'd0;
                bz = $urandom_range(1) ? 4'd15 : 4'd0;
            end
            if (sel < 45)
                send_request(ACT_WRITE, bx, by, bz, ($urandom_range(99) < 65), $urandom);
            else if (sel < 90)
                send_request(ACT_MESH, bx, by, bz, 1'($urandom_range(1)), $urandom);
            else if (sel < 96)
                send_request(ACT_START, bx, by, bz, 1'($urandom_range(1)), $urandom);
            else
                send_request(2'd3, bx, by, bz, 1'($urandom_range(1)), $urandom);
        end
    endtask

    // Repeated meshes of one cube to advance the vertex counter
    task automatic test_vertex_count();
        int i;
        send_request(ACT_START, 0, 0, 0, 0, 0);
        send_request(ACT_WRITE, 8, 8, 8, 1, 32'hCAFE_0001);
        send_request(ACT_WRITE, 8, 9, 8, 0, 0);
        for (i = 0; i < 20; i++)
            send_request(ACT_MESH, 8, 8, 8, 0, 0);
        send_request(ACT_START, 0, 0, 0, 0, 0);
        send_request(ACT_MESH, 8, 8, 8, 0, 0);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < GRID*GRID*GRID; i++)
        begin
            shadow_solid[i] = 1'b0;
            shadow_color[i] = '0;
        end
        shadow_vcount = '0;
        shadow_dirty = 1'b0;
        shadow_ovf = 1'b0;
        shadow_outside = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_idling(0, 0);
        test_directed();
        write_outside(1'b1);
        test_directed();
        set_idling(55, 0);
        test_random(40, 4);
        write_outside(1'b0);
        set_idling(0, 55);
        test_random(40, 4);
        write_outside(1'b1);
        set_idling(21, 21);
        test_random(40, 16);
        set_idling(0, 0);
        test_random(30, 4);
        set_idling(0, 0);
        test_vertex_count();
        write_outside(1'b0);
        set_idling(21, 21);
        test_random(20, 4);
        wait_drained();

        if (mismatches == 0 && face_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
